// File: rtl/coap_pkg.sv
// shared types and constants for the coap message parser
package coap_pkg;

  localparam int MaxOptionsDefault = 16;

  localparam logic [3:0] PH_HEADER  = 4'd0;
  localparam logic [3:0] PH_TOKEN   = 4'd1;
  localparam logic [3:0] PH_OPT     = 4'd2;
  localparam logic [3:0] PH_D13     = 4'd3;
  localparam logic [3:0] PH_D14A    = 4'd4;
  localparam logic [3:0] PH_D14B    = 4'd5;
  localparam logic [3:0] PH_L13     = 4'd6;
  localparam logic [3:0] PH_L14A    = 4'd7;
  localparam logic [3:0] PH_L14B    = 4'd8;
  localparam logic [3:0] PH_VALUE   = 4'd9;
  localparam logic [3:0] PH_PAYLOAD = 4'd10;
  localparam logic [3:0] PH_DONE    = 4'd11;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HDR_SHORT  = 3'd1;
  localparam logic [2:0] ST_BAD_VER    = 3'd2;
  localparam logic [2:0] ST_TOKEN_BAD  = 3'd3;
  localparam logic [2:0] ST_OPT_SHORT  = 3'd4;
  localparam logic [2:0] ST_DELTA15    = 3'd5;
  localparam logic [2:0] ST_LEN15      = 3'd6;
  localparam logic [2:0] ST_OPT_BIG    = 3'd7;

  localparam logic KIND_OPTION = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
  localparam logic [3:0]  NIB_EXT8       = 4'd13;
  localparam logic [3:0]  NIB_EXT16      = 4'd14;
  localparam logic [3:0]  NIB_BAD        = 4'd15;
  localparam logic [15:0] EXT8_BIAS      = 16'd13;
  localparam logic [15:0] EXT16_BIAS     = 16'd269;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [1:0]  msg_type;
    logic [7:0]  code;
    logic [15:0] message_id;
    logic [3:0]  token_length;
    logic [63:0] token_value;
    logic [15:0] option_number;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    logic [7:0]  option_count;
  } out_item_t;

  // one byte tagged with its position, passed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] pos;
  } byte_rec_t;

endpackage

// File: rtl/coap_message_parser_core.sv
// top level of the coap message parser
// a byte's records pass through the front queue and then the two-entry output buffer
// throughput: one byte per cycle while the output side drains; a byte that makes
//   two records fills the output buffer and holds the parser until one leaves;
// the rate is set by the two-entry output buffer, which takes a byte while its last record leaves
// reset: synchronous active-low rst_n clears the queue, parser state and buffers
module coap_message_parser_core #(
  parameter int MAX_OPTIONS = coap_pkg::MaxOptionsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  coap_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output coap_pkg::out_item_t out_data
);
  import coap_pkg::*;

  logic      q_valid, q_ready;
  byte_rec_t q_data;

  coap_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  coap_back #(.MAX_OPTIONS(MAX_OPTIONS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );
endmodule

// File: rtl/coap_front.sv
// input side: accepts bytes, tags positions, small fifo toward the parser
module coap_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  coap_pkg::in_item_t  in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output coap_pkg::byte_rec_t q_data
);
  import coap_pkg::*;

  localparam int Depth = 4;

  byte_rec_t   mem_r [Depth];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;
  logic [15:0] pos_r;
  logic        push, pop;

  assign in_ready = (cnt_r != 3'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 3'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data_byte: in_data.data_byte, last: in_data.last, pos: pos_r};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      if (push) begin
        wp_r  <= wp_r + 2'd1;
        pos_r <= in_data.last ? 16'd0 : pos_r + 16'd1;
      end
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(Depth)) else $error("queue overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'(Depth)) |-> !in_ready) else $error("ready when full");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_data.last) |=> (pos_r == 16'd0)) else $error("position not cleared");
endmodule

// File: rtl/coap_back.sv
// parser side: walks the message state and emits option and end records
module coap_back #(
  parameter int MAX_OPTIONS = coap_pkg::MaxOptionsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  coap_pkg::byte_rec_t  q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output coap_pkg::out_item_t  out_data
);
  import coap_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [63:0] tok_r, tok_nxt;
  logic [15:0] run_r, run_nxt, dlt_r, dlt_nxt, len_r, len_nxt;
  logic [15:0] vst_r, vst_nxt, rem_r, rem_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        pay_r, pay_nxt;

  // two-entry output buffer
  out_item_t   ob_r [2];
  logic        ob_rp_r, ob_wp_r;
  logic [1:0]  ob_cnt_r;

  logic        take;
  logic        ob_pop;
  logic        emit_opt;
  out_item_t   opt_rec, end_rec;
  logic [7:0]  b;
  logic [15:0] pos, pos1;
  logic [3:0]  dn;
  logic        fin, aft;
  logic [2:0]  st;
  logic [1:0]  nrec;

  assign b    = q_data.data_byte;
  assign pos  = q_data.pos;
  assign pos1 = pos + 16'd1;
  assign dn   = b[7:4];
  assign ob_pop  = out_valid && out_ready;
  assign q_ready = (ob_cnt_r == 2'd0) || ((ob_cnt_r == 2'd1) && out_ready);
  assign take    = q_valid && q_ready;

  always_comb begin
    phase_nxt = phase_r; hdr_nxt = hdr_r; tok_nxt = tok_r; run_nxt = run_r;
    dlt_nxt = dlt_r; len_nxt = len_r; vst_nxt = vst_r; rem_nxt = rem_r;
    seen_nxt = seen_r; err_nxt = err_r; pay_nxt = pay_r;
    emit_opt = 1'b0; fin = 1'b0; aft = 1'b0;
    if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_HEADER: begin
          unique case (pos[1:0])
            2'd0: hdr_nxt[31:24] = b;
            2'd1: hdr_nxt[23:16] = b;
            2'd2: hdr_nxt[15:8]  = b;
            default: hdr_nxt[7:0] = b;
          endcase
          if (pos >= 16'd3) begin
            if (hdr_nxt[31:30] != 2'd1) err_nxt = ST_BAD_VER;
            else if (hdr_nxt[27:24] > 4'd8) err_nxt = ST_TOKEN_BAD;
            else if (hdr_nxt[27:24] == 4'd0) phase_nxt = PH_OPT;
            else begin
              rem_nxt = {12'd0, hdr_nxt[27:24]};
              phase_nxt = PH_TOKEN;
            end
          end
        end
        PH_TOKEN: begin
          tok_nxt = {tok_r[55:0], b};
          rem_nxt = rem_r - 16'd1;
          if (rem_nxt == 16'd0) phase_nxt = PH_OPT;
        end
        PH_OPT: begin
          if (b == PAYLOAD_MARKER) begin
            vst_nxt = pos1;
            phase_nxt = PH_PAYLOAD;
          end else if (seen_r >= 8'(MAX_OPTIONS)) begin
            phase_nxt = PH_DONE;
          end else begin
            len_nxt = {12'd0, b[3:0]};
            if (dn == NIB_BAD) err_nxt = ST_DELTA15;
            else if (dn == NIB_EXT8) phase_nxt = PH_D13;
            else if (dn == NIB_EXT16) phase_nxt = PH_D14A;
            else begin
              dlt_nxt = {12'd0, dn};
              aft = 1'b1;
            end
          end
        end
        PH_D13: begin
          dlt_nxt = {8'd0, b} + EXT8_BIAS;
          aft = 1'b1;
        end
        PH_D14A: begin
          dlt_nxt = {8'd0, b};
          phase_nxt = PH_D14B;
        end
        PH_D14B: begin
          dlt_nxt = {dlt_r[7:0], b} + EXT16_BIAS;
          aft = 1'b1;
        end
        PH_L13: begin
          len_nxt = {8'd0, b} + EXT8_BIAS;
          fin = 1'b1;
        end
        PH_L14A: begin
          len_nxt = {8'd0, b};
          phase_nxt = PH_L14B;
        end
        PH_L14B: begin
          len_nxt = {len_r[7:0], b} + EXT16_BIAS;
          fin = 1'b1;
        end
        PH_VALUE: begin
          rem_nxt = rem_r - 16'd1;
          if (rem_nxt == 16'd0) emit_opt = 1'b1;
        end
        PH_PAYLOAD: pay_nxt = 1'b1;
        default: ;
      endcase
      if (aft) begin
        if (len_nxt == 16'd15) err_nxt = ST_LEN15;
        else if (len_nxt == 16'd13) phase_nxt = PH_L13;
        else if (len_nxt == 16'd14) phase_nxt = PH_L14A;
        else fin = 1'b1;
      end
      if (fin) begin
        vst_nxt = pos1;
        if (len_nxt == 16'd0) emit_opt = 1'b1;
        else begin
          rem_nxt = len_nxt;
          phase_nxt = PH_VALUE;
        end
      end
      if (emit_opt) begin
        run_nxt  = run_r + dlt_nxt;
        seen_nxt = seen_r + 8'd1;
        phase_nxt = PH_OPT;
      end
    end
  end

  always_comb begin
    st = err_nxt;
    if (st == ST_OK) begin
      unique case (phase_nxt)
        PH_HEADER: st = ST_HDR_SHORT;
        PH_TOKEN:  st = ST_TOKEN_BAD;
        PH_D13, PH_D14A, PH_D14B, PH_L13, PH_L14A, PH_L14B: st = ST_OPT_SHORT;
        PH_VALUE:  st = ST_OPT_BIG;
        default: ;
      endcase
    end
    opt_rec = '{kind: KIND_OPTION, status: ST_OK, msg_type: hdr_nxt[29:28],
                code: hdr_nxt[23:16], message_id: hdr_nxt[15:0],
                token_length: hdr_nxt[27:24], token_value: tok_nxt,
                option_number: run_nxt, value_offset: vst_nxt,
                value_length: len_nxt, option_count: seen_nxt};
    end_rec = opt_rec;
    end_rec.kind = KIND_END;
    end_rec.status = st;
    if (st == ST_OK && phase_nxt == PH_PAYLOAD && pay_nxt) begin
      end_rec.value_offset = vst_nxt;
      end_rec.value_length = pos1 - vst_nxt;
    end else begin
      end_rec.value_offset = '0;
      end_rec.value_length = '0;
    end
  end

  assign nrec = 2'(emit_opt) + 2'(q_data.last);
  assign out_valid = (ob_cnt_r != 2'd0);
  assign out_data  = ob_r[ob_rp_r];

  always_ff @(posedge clk) begin
    if (take && emit_opt) ob_r[ob_wp_r] <= opt_rec;
    if (take && q_data.last) ob_r[ob_wp_r ^ emit_opt] <= end_rec;
    if (!rst_n) begin
      ob_rp_r <= 1'b0; ob_wp_r <= 1'b0; ob_cnt_r <= '0;
    end else begin
      if (take) ob_wp_r <= ob_wp_r ^ nrec[0];
      if (ob_pop) ob_rp_r <= ~ob_rp_r;
      ob_cnt_r <= ob_cnt_r - 2'(ob_pop) + (take ? nrec : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && q_data.last)) begin
      phase_r <= PH_HEADER; hdr_r <= '0; tok_r <= '0; run_r <= '0; dlt_r <= '0;
      len_r <= '0; vst_r <= '0; rem_r <= '0; seen_r <= '0; err_r <= ST_OK;
      pay_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt; hdr_r <= hdr_nxt; tok_r <= tok_nxt; run_r <= run_nxt;
      dlt_r <= dlt_nxt; len_r <= len_nxt; vst_r <= vst_nxt; rem_r <= rem_nxt;
      seen_r <= seen_nxt; err_r <= err_nxt; pay_r <= pay_nxt;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= 2'd2) else $error("output buffer overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_cnt_r == 2'd2) |-> !q_ready) else $error("byte taken with buffer full");
  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit_opt) |-> (seen_r < 8'(MAX_OPTIONS))) else $error("option limit passed");
endmodule

// File: test/testbench.sv
// self-checking testbench for the coap message parser core
`timescale 1ns / 100ps

module testbench;
  import coap_pkg::*;

  localparam int MaxOpts = MaxOptionsDefault;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  coap_message_parser_core #(.MAX_OPTIONS(MaxOpts)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser shadow state
  logic [15:0] p_pos;
  logic [3:0]  p_phase;
  logic [31:0] p_hdr;
  logic [63:0] p_tok;
  logic [15:0] p_optnum, p_delta, p_len, p_vstart, p_remain;
  logic [7:0]  p_count;
  logic [2:0]  p_err;
  logic        p_payload;

  in_item_t  pending_bytes[$];
  out_item_t expected_records[$];
  int mismatches = 0;
  int bytes_queued = 0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;
  bit calm = 1'b0;

  function automatic void clear_parser();
    p_pos = '0; p_phase = PH_HEADER; p_hdr = '0; p_tok = '0; p_optnum = '0;
    p_delta = '0; p_len = '0; p_vstart = '0; p_remain = '0; p_count = '0;
    p_err = ST_OK; p_payload = 1'b0;
  endfunction

  function automatic void emit_record(logic kind, logic [2:0] st, logic [15:0] num,
                                      logic [15:0] off, logic [15:0] len);
    out_item_t r;
    r.kind = kind; r.status = st;
    r.msg_type = p_hdr[29:28]; r.code = p_hdr[23:16]; r.message_id = p_hdr[15:0];
    r.token_length = p_hdr[27:24]; r.token_value = p_tok;
    r.option_number = num; r.value_offset = off; r.value_length = len;
    r.option_count = p_count;
    expected_records.push_back(r);
  endfunction

  function automatic void close_option();
    p_optnum = p_optnum + p_delta;
    p_count = p_count + 8'd1;
    emit_record(KIND_OPTION, ST_OK, p_optnum, p_vstart, p_len);
    p_phase = PH_OPT;
  endfunction

  function automatic void end_opt_header(logic [15:0] pos);
    p_vstart = pos + 16'd1;
    if (p_len == 0) close_option();
    else begin
      p_remain = p_len;
      p_phase = PH_VALUE;
    end
  endfunction

  function automatic void delta_done(logic [15:0] pos);
    if (p_len == 16'd15) p_err = ST_LEN15;
    else if (p_len == 16'd13) p_phase = PH_L13;
    else if (p_len == 16'd14) p_phase = PH_L14A;
    else end_opt_header(pos);
  endfunction

  function automatic void predict_byte(in_item_t it);
    logic [15:0] pos;
    logic [7:0] b;
    logic [2:0] st;
    logic [15:0] off, len;
    pos = p_pos; b = it.data_byte;
    if (p_err == ST_OK) begin
      case (p_phase)
        PH_HEADER: begin
          p_hdr = p_hdr | ({24'd0, b} << (24 - 8 * pos[1:0]));
          if (pos >= 3) begin
            if (p_hdr[31:30] != 2'd1) p_err = ST_BAD_VER;
            else if (p_hdr[27:24] > 4'd8) p_err = ST_TOKEN_BAD;
            else if (p_hdr[27:24] == 0) p_phase = PH_OPT;
            else begin
              p_remain = {12'd0, p_hdr[27:24]};
              p_phase = PH_TOKEN;
            end
          end
        end
        PH_TOKEN: begin
          p_tok = {p_tok[55:0], b};
          p_remain = p_remain - 16'd1;
          if (p_remain == 0) p_phase = PH_OPT;
        end
        PH_OPT: begin
          if (b == PAYLOAD_MARKER) begin
            p_vstart = pos + 16'd1;
            p_phase = PH_PAYLOAD;
          end else if (p_count >= MaxOpts) p_phase = PH_DONE;
          else begin
            p_len = {12'd0, b[3:0]};
            if (b[7:4] == NIB_BAD) p_err = ST_DELTA15;
            else if (b[7:4] == NIB_EXT8) p_phase = PH_D13;
            else if (b[7:4] == NIB_EXT16) p_phase = PH_D14A;
            else begin
              p_delta = {12'd0, b[7:4]};
              delta_done(pos);
            end
          end
        end
        PH_D13: begin
          p_delta = {8'd0, b} + EXT8_BIAS;
          delta_done(pos);
        end
        PH_D14A: begin
          p_delta = {8'd0, b};
          p_phase = PH_D14B;
        end
        PH_D14B: begin
          p_delta = {p_delta[7:0], b} + EXT16_BIAS;
          delta_done(pos);
        end
        PH_L13: begin
          p_len = {8'd0, b} + EXT8_BIAS;
          end_opt_header(pos);
        end
        PH_L14A: begin
          p_len = {8'd0, b};
          p_phase = PH_L14B;
        end
        PH_L14B: begin
          p_len = {p_len[7:0], b} + EXT16_BIAS;
          end_opt_header(pos);
        end
        PH_VALUE: begin
          p_remain = p_remain - 16'd1;
          if (p_remain == 0) close_option();
        end
        PH_PAYLOAD: p_payload = 1'b1;
        default: ;
      endcase
    end
    p_pos = pos + 16'd1;
    if (it.last) begin
      st = p_err; off = '0; len = '0;
      if (st == ST_OK) begin
        case (p_phase)
          PH_HEADER: st = ST_HDR_SHORT;
          PH_TOKEN: st = ST_TOKEN_BAD;
          PH_D13, PH_D14A, PH_D14B, PH_L13, PH_L14A, PH_L14B: st = ST_OPT_SHORT;
          PH_VALUE: st = ST_OPT_BIG;
          default: ;
        endcase
      end
      if (st == ST_OK && p_phase == PH_PAYLOAD && p_payload) begin
        off = p_vstart;
        len = pos + 16'd1 - p_vstart;
      end
      emit_record(KIND_END, st, p_optnum, off, len);
      clear_parser();
    end
  endfunction

  // message building
  in_item_t msg_bytes[$];

  function automatic void put_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte = b; it.last = 1'b0;
    msg_bytes.push_back(it);
  endfunction

  function automatic void commit_message();
    in_item_t it;
    if (msg_bytes.size() == 0) put_byte(8'($urandom));
    msg_bytes[msg_bytes.size() - 1].last = 1'b1;
    while (msg_bytes.size() > 0) begin
      it = msg_bytes.pop_front();
      pending_bytes.push_back(it);
      bytes_queued++;
    end
  endfunction

  function automatic void put_header(logic [1:0] ver, logic [3:0] tkl);
    int i;
    put_byte({ver, 2'($urandom), tkl});
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    for (i = 0; i < tkl && i < 8; i++) put_byte(8'($urandom));
  endfunction

  // nibble plus extension for delta or length
  function automatic void ext_field(int v, output logic [3:0] nib, output int nx,
                                    output logic [15:0] xv);
    if (v < 13) begin
      nib = 4'(v); nx = 0; xv = '0;
    end else if (v < 269) begin
      nib = NIB_EXT8; nx = 1; xv = 16'(v - 13);
    end else begin
      nib = NIB_EXT16; nx = 2; xv = 16'(v - 269);
    end
  endfunction

  function automatic void put_option(int delta, int len);
    logic [3:0] dn, ln;
    int dx, lx, i;
    logic [15:0] dv, lv;
    ext_field(delta, dn, dx, dv);
    ext_field(len, ln, lx, lv);
    put_byte({dn, ln});
    if (dx == 1) put_byte(dv[7:0]);
    if (dx == 2) begin put_byte(dv[15:8]); put_byte(dv[7:0]); end
    if (lx == 1) put_byte(lv[7:0]);
    if (lx == 2) begin put_byte(lv[15:8]); put_byte(lv[7:0]); end
    for (i = 0; i < len; i++) put_byte(8'($urandom));
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 12);
      5, 6, 7: return $urandom_range(13, 268);
      8: return $urandom_range(269, 300);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 12);
      6, 7, 8: return $urandom_range(13, 40);
      default: return $urandom_range(269, 280);
    endcase
  endfunction

  function automatic void random_message();
    int nopt, i, cut;
    nopt = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0) put_header(2'($urandom), 4'($urandom));
    else put_header(2'd1, 4'($urandom_range(0, 8)));
    for (i = 0; i < nopt; i++) put_option(pick_value(), pick_len());
    if ($urandom_range(0, 2) != 0) begin
      put_byte(PAYLOAD_MARKER);
      cut = $urandom_range(0, 6);
      for (i = 0; i < cut; i++) put_byte(8'($urandom));
    end
    case ($urandom_range(0, 9))
      0: begin
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
      1: put_byte(8'($urandom));
      default: ;
    endcase
    commit_message();
  endfunction

  initial begin
    int i;
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: short header, bad version, bad token length, short token, then option, payload and option-limit cases
    put_byte(8'h40); put_byte(8'h01); commit_message();
    put_byte(8'h80); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00); commit_message();
    put_byte(8'h49); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); commit_message();
    put_header(2'd1, 4'd8); void'(msg_bytes.pop_back()); commit_message();
    put_byte(8'h7F); put_byte(8'hFF); put_byte(8'h00); put_byte(8'hFF);
    put_byte(8'hF0); commit_message();
    put_header(2'd1, 4'd0); put_byte(8'h0F); commit_message();
    put_header(2'd1, 4'd8); put_option(0, 0); put_option(12, 3); put_option(13, 268);
    put_option(269, 13); put_option(65535, 0); put_option(1000, 269);
    put_byte(PAYLOAD_MARKER); put_byte(8'h00); put_byte(8'hFF); commit_message();
    put_header(2'd1, 4'd0); put_byte(8'hD0); commit_message();
    put_header(2'd1, 4'd0); put_byte(8'hE0); put_byte(8'h00); commit_message();
    put_header(2'd1, 4'd0); put_byte(8'h05); put_byte(8'h00); commit_message();
    put_header(2'd1, 4'd2); put_byte(8'hFF); commit_message();
    for (i = 0; i < MaxOpts; i++) put_option(1, 1);
    put_byte(8'h11); put_byte(8'h22); commit_message();
    put_header(2'd1, 4'd0);
    for (i = 0; i < MaxOpts; i++) put_option(0, 0);
    put_byte(PAYLOAD_MARKER); put_byte(8'h33); commit_message();
    wait (pending_bytes.size() == 0);
    hold_off = 1'b1;
    wait (expected_records.size() == 0);
    @(posedge clk);
    hold_off = 1'b0;
    while (bytes_queued < 1100) begin
      random_message();
      wait (pending_bytes.size() < 200);
    end
    calm = 1'b1;
    wait (pending_bytes.size() == 0);
    stimulus_done = 1'b1;
  end

  // byte driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_byte(in_data);
        void'(pending_bytes.pop_front());
      end
      if (in_valid && !in_ready) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && (in_valid && in_ready) && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(1, 19) - 1;
        in_valid <= 1'b0;
      end else if (!hold_off && pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_bytes[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // record monitor
  int out_gap = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected record %h", out_data);
        end else begin
          want = expected_records.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("record mismatch: expected %h actual %h", want, out_data);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    wait (expected_records.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
